FILE: rtl/core/conv2d_3x3_replicate_border_macros.svh
// Assertion macros for the 3x3 convolution block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef CONV2D_3X3_REPLICATE_BORDER_MACROS_SVH
`define CONV2D_3X3_REPLICATE_BORDER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on i_clk, disabled while i_rst_n is low.
`define CONV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("conv3x3 assertion failed");
// Next-cycle implication, sampled on i_clk, disabled while i_rst_n is low.
`define CONV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("conv3x3 assertion failed");
`else
`define CONV_ASSERT_IMP(lbl, ante, cons)
`define CONV_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/conv3x3_pkg.sv
// Shared types, field widths, register indexes and the rounding function
// of the 3x3 convolution block. No dependencies.
package conv3x3_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_OUT_W  = 10;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int COEF_W     = 16;
    localparam int COEF_REG_W = 48;
    localparam int MAX_HEIGHT = 4096;
    localparam int CFG_ADDR_W = 3;
    localparam int FRAC_W     = 12;
    localparam int PROD_W     = 25;
    localparam int ROWSUM_W   = 27;
    localparam int SUM_W      = 28;
    localparam int QUOT_W     = SUM_W - FRAC_W;
    localparam int TDATA_W    = 32;
    localparam int NUM_KINDS  = 4;
    localparam int JOB_DEPTH  = 4;
    localparam int JOB_PTR_W  = 2;
    localparam int JOB_CNT_W  = 3;

    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    localparam t_cfg_addr REG_FRAME_WIDTH  = t_cfg_addr'(0);
    localparam t_cfg_addr REG_FRAME_HEIGHT = t_cfg_addr'(1);
    localparam t_cfg_addr REG_COEF_TOP     = t_cfg_addr'(2);
    localparam t_cfg_addr REG_COEF_MID     = t_cfg_addr'(3);
    localparam t_cfg_addr REG_COEF_BOT     = t_cfg_addr'(4);

    localparam logic [FW_W-1:0]       FW_RESET       = 11'd1024;
    localparam logic [FH_W-1:0]       FH_RESET       = 13'd4096;
    localparam logic [COEF_REG_W-1:0] COEF_MID_RESET = 48'h0000_1000_0000;

    localparam logic [FRAC_W-1:0] FRAC_HALF = 12'h800;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [2:0][2:0] t_win;

    // which of the up to four results of one pixel a filter pass produces
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ABOVE_LEFT = 2'd0;
    localparam t_kind KIND_ABOVE_EDGE = 2'd1;
    localparam t_kind KIND_LAST_LEFT  = 2'd2;
    localparam t_kind KIND_LAST_EDGE  = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic                 done;
    } t_meta;

    typedef struct packed {
        t_win                 win;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic [NUM_KINDS-1:0] mask;
        logic                 xge1;
        logic                 xge2;
    } t_job;

    // Round Q.12 sum to nearest, ties to even, then clamp to 0..255.
    function automatic t_pix round_sat(logic signed [SUM_W-1:0] s);
        logic signed [QUOT_W-1:0] q;
        logic        [FRAC_W-1:0] fr;
        logic                     up;
        logic signed [QUOT_W:0]   qr;
        t_pix                     res;
        q  = s[SUM_W-1:FRAC_W];
        fr = s[FRAC_W-1:0];
        up = (fr > FRAC_HALF) || ((fr == FRAC_HALF) && q[0]);
        qr = (QUOT_W+1)'(q) + $signed({{QUOT_W{1'b0}}, up});
        if (qr[QUOT_W]) begin
            res = '0;
        end else if (qr > $signed((QUOT_W+1)'(255))) begin
            res = '1;
        end else begin
            res = qr[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/conv2d_3x3_replicate_border.sv
// 3x3 convolution with replicated border over a raster-order pixel stream.
// Depends on conv3x3_pkg and conv2d_3x3_replicate_border_macros.svh.

// The block takes one 8-bit pixel per transaction in raster order and returns
// filtered pixels tagged with row, column and an end-of-frame mark (tlast).
// Results lag the input by one row plus one pixel; at each row end two results
// come out, and during the last row two per pixel (four at its row end). The
// input takes one pixel per clock as long as the four-entry job queue between
// the window stage and the shared filter pipeline has room; each result makes
// one pass of that pipeline, which stalls while the output is held, so over a
// frame without output stalls the intake is one pixel per cycle except where
// a pixel yields more than one result, where it follows the result rate. The
// line buffers are read in the accept cycle. Configuration is to be written
// through the plain write port only while the block is idle, which the block
// does not enforce; the kernel resets to identity, the frame to 1024 by 4096.
module conv2d_3x3_replicate_border #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream: tdata = pixel_in [7:0]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [conv3x3_pkg::PIX_W-1:0]       s_axis_tdata,
    // master stream: tdata = pixel_out [7:0], out_row [19:8], out_col [29:20],
    // zero [31:30]; tlast = frame_done
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [conv3x3_pkg::TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [conv3x3_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [conv3x3_pkg::COEF_REG_W-1:0]  i_cfg_wdata
);

    `include "conv2d_3x3_replicate_border_macros.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    // configuration registers
    logic [conv3x3_pkg::FW_W-1:0]       r_frame_width;
    logic [conv3x3_pkg::FH_W-1:0]       r_frame_height;
    logic [conv3x3_pkg::COEF_REG_W-1:0] r_coef [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= conv3x3_pkg::FW_RESET;
            r_frame_height <= conv3x3_pkg::FH_RESET;
            r_coef[0]      <= '0;
            r_coef[1]      <= conv3x3_pkg::COEF_MID_RESET;
            r_coef[2]      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                conv3x3_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[conv3x3_pkg::FW_W-1:0];
                conv3x3_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[conv3x3_pkg::FH_W-1:0];
                conv3x3_pkg::REG_COEF_TOP:     r_coef[0]      <= i_cfg_wdata;
                conv3x3_pkg::REG_COEF_MID:     r_coef[1]      <= i_cfg_wdata;
                conv3x3_pkg::REG_COEF_BOT:     r_coef[2]      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective geometry: zero reads as one, oversize saturates
    logic [WW-1:0]                  w_eff;
    logic [conv3x3_pkg::FH_W-1:0]   h_eff;
    logic [CW-1:0]                  w_last;
    logic [conv3x3_pkg::ROW_W-1:0]  h_last;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = conv3x3_pkg::FH_W'(1);
        end else if (int'(r_frame_height) > conv3x3_pkg::MAX_HEIGHT) begin
            h_eff = conv3x3_pkg::FH_W'(conv3x3_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
        w_last = CW'(w_eff - WW'(1));
        h_last = conv3x3_pkg::ROW_W'(h_eff - conv3x3_pkg::FH_W'(1));
    end

    // ---------------- accept stage: position counters, line buffer read
    logic [CW-1:0]                   r_col, n_col;
    logic [conv3x3_pkg::ROW_W-1:0]   r_row, n_row;
    logic                            s_accept;
    logic                            wrap_col;
    logic [conv3x3_pkg::FH_W-1:0]    row_pre;
    logic [CW-1:0]                   a_x;
    logic [conv3x3_pkg::ROW_W-1:0]   a_y;
    logic                            a_row_end;
    logic                            a_last_row;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        wrap_col   = (WW'(r_col) >= w_eff);
        row_pre    = wrap_col ? (conv3x3_pkg::FH_W'(r_row) + conv3x3_pkg::FH_W'(1))
                              : conv3x3_pkg::FH_W'(r_row);
        a_x        = wrap_col ? '0 : r_col;
        a_y        = (row_pre >= h_eff) ? '0 : row_pre[conv3x3_pkg::ROW_W-1:0];
        a_row_end  = (a_x == w_last);
        a_last_row = (a_y == h_last);
        if (a_row_end) begin
            n_col = '0;
            n_row = a_last_row ? '0 : a_y + conv3x3_pkg::ROW_W'(1);
        end else begin
            n_col = a_x + CW'(1);
            n_row = a_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (s_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line buffers: newer holds row y-1, older row y-2
    conv3x3_pkg::t_pix r_newer_line [MAX_WIDTH];
    conv3x3_pkg::t_pix r_older_line [MAX_WIDTH];
    conv3x3_pkg::t_pix r_rd_new;
    conv3x3_pkg::t_pix r_rd_old;

    logic                            r_b_valid;
    conv3x3_pkg::t_pix               r_b_pix;
    logic [CW-1:0]                   r_b_x;
    logic [conv3x3_pkg::ROW_W-1:0]   r_b_y;
    logic                            r_b_row_end;
    logic                            r_b_last_row;

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_newer_line[a_x] <= s_axis_tdata;
        end
        r_rd_new <= r_newer_line[a_x];
    end

    // older takes the old newer entry in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_older_line[r_b_x] <= r_rd_new;
        end
        r_rd_old <= r_older_line[a_x];
    end

    // with a one-pixel row the next read hits the entry being written: bypass
    logic              fwd_set;
    logic              r_fwd_valid;
    conv3x3_pkg::t_pix r_fwd_data;

    assign fwd_set = r_b_valid && s_accept && (a_x == r_b_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= fwd_set;
        end
        r_fwd_data <= r_rd_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= s_accept;
        end
        if (s_accept) begin
            r_b_pix      <= s_axis_tdata;
            r_b_x        <= a_x;
            r_b_y        <= a_y;
            r_b_row_end  <= a_row_end;
            r_b_last_row <= a_last_row;
        end
    end

    // ---------------- window stage: shift window, build filter job
    conv3x3_pkg::t_win r_win, n_win;
    conv3x3_pkg::t_pix b_old;
    conv3x3_pkg::t_pix b_m;
    conv3x3_pkg::t_pix b_t;
    conv3x3_pkg::t_job b_job;
    logic              b_xge1;

    always_comb begin
        b_old  = r_fwd_valid ? r_fwd_data : r_rd_old;
        b_m    = (r_b_y != '0) ? r_rd_new : r_b_pix;
        b_t    = (r_b_y >= conv3x3_pkg::ROW_W'(2)) ? b_old : b_m;
        b_xge1 = (r_b_x != '0);
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = b_t;
        n_win[1][2] = b_m;
        n_win[2][2] = r_b_pix;

        b_job.win  = n_win;
        b_job.row  = r_b_y;
        b_job.col  = conv3x3_pkg::COL_OUT_W'(r_b_x);
        b_job.xge1 = b_xge1;
        b_job.xge2 = (r_b_x >= CW'(2));
        b_job.mask[conv3x3_pkg::KIND_ABOVE_LEFT] = (r_b_y != '0) && b_xge1;
        b_job.mask[conv3x3_pkg::KIND_ABOVE_EDGE] = (r_b_y != '0) && r_b_row_end;
        b_job.mask[conv3x3_pkg::KIND_LAST_LEFT]  = r_b_last_row && b_xge1;
        b_job.mask[conv3x3_pkg::KIND_LAST_EDGE]  = r_b_last_row && r_b_row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_b_valid) begin
            r_win <= n_win;
        end
    end

    // ---------------- job queue
    conv3x3_pkg::t_job                  r_jobs [conv3x3_pkg::JOB_DEPTH];
    logic [conv3x3_pkg::JOB_PTR_W-1:0]  r_wr_ptr;
    logic [conv3x3_pkg::JOB_PTR_W-1:0]  r_rd_ptr;
    logic [conv3x3_pkg::JOB_CNT_W-1:0]  r_count;
    logic [conv3x3_pkg::JOB_CNT_W:0]    occ;
    logic                               job_push;
    logic                               job_pop;

    assign job_push      = r_b_valid && (b_job.mask != '0);
    assign occ           = (conv3x3_pkg::JOB_CNT_W+1)'(r_count)
                         + (conv3x3_pkg::JOB_CNT_W+1)'(r_b_valid);
    // reserve a slot for the pixel still in the window stage
    assign s_axis_tready = (occ < (conv3x3_pkg::JOB_CNT_W+1)'(conv3x3_pkg::JOB_DEPTH));

    always_ff @(posedge i_clk) begin
        if (job_push) begin
            r_jobs[r_wr_ptr] <= b_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (job_push) begin
                r_wr_ptr <= r_wr_ptr + conv3x3_pkg::JOB_PTR_W'(1);
            end
            if (job_pop) begin
                r_rd_ptr <= r_rd_ptr + conv3x3_pkg::JOB_PTR_W'(1);
            end
            case ({job_push, job_pop})
                2'b10:   r_count <= r_count + conv3x3_pkg::JOB_CNT_W'(1);
                2'b01:   r_count <= r_count - conv3x3_pkg::JOB_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // ---------------- issue: one filter pass per cycle from the head job while the pipeline is not stalled
    logic                               pipe_en;
    logic                               issue;
    logic                               issue_last;
    conv3x3_pkg::t_job                  head;
    logic [conv3x3_pkg::NUM_KINDS-1:0]  r_issued;
    logic [conv3x3_pkg::NUM_KINDS-1:0]  rem;
    logic [conv3x3_pkg::NUM_KINDS-1:0]  kind_bit;
    conv3x3_pkg::t_kind                 kind;
    logic [1:0]                         sel_r [3];
    logic [1:0]                         sel_c [3];
    conv3x3_pkg::t_win                  c_pix;
    conv3x3_pkg::t_meta                 c_meta;
    logic                               r_out_valid;

    assign pipe_en = !r_out_valid || m_axis_tready;
    assign issue   = pipe_en && (r_count != '0);
    assign job_pop = issue && issue_last;

    always_comb begin
        head = r_jobs[r_rd_ptr];
        rem  = head.mask & ~r_issued;
        if (rem[conv3x3_pkg::KIND_ABOVE_LEFT]) begin
            kind = conv3x3_pkg::KIND_ABOVE_LEFT;
        end else if (rem[conv3x3_pkg::KIND_ABOVE_EDGE]) begin
            kind = conv3x3_pkg::KIND_ABOVE_EDGE;
        end else if (rem[conv3x3_pkg::KIND_LAST_LEFT]) begin
            kind = conv3x3_pkg::KIND_LAST_LEFT;
        end else begin
            kind = conv3x3_pkg::KIND_LAST_EDGE;
        end
        kind_bit   = conv3x3_pkg::NUM_KINDS'(1) << kind;
        issue_last = ((rem & ~kind_bit) == '0);

        // rows: above-row results use the full window, last-row ones repeat bottom
        // cols: left neighbor of the current pixel, or the row-end pixel itself
        case (kind)
            conv3x3_pkg::KIND_ABOVE_LEFT: begin
                sel_r[0] = 2'd0; sel_r[1] = 2'd1; sel_r[2] = 2'd2;
                sel_c[0] = head.xge2 ? 2'd0 : 2'd1; sel_c[1] = 2'd1; sel_c[2] = 2'd2;
                c_meta.row = head.row - conv3x3_pkg::ROW_W'(1);
                c_meta.col = head.col - conv3x3_pkg::COL_OUT_W'(1);
            end
            conv3x3_pkg::KIND_ABOVE_EDGE: begin
                sel_r[0] = 2'd0; sel_r[1] = 2'd1; sel_r[2] = 2'd2;
                sel_c[0] = head.xge1 ? 2'd1 : 2'd2; sel_c[1] = 2'd2; sel_c[2] = 2'd2;
                c_meta.row = head.row - conv3x3_pkg::ROW_W'(1);
                c_meta.col = head.col;
            end
            conv3x3_pkg::KIND_LAST_LEFT: begin
                sel_r[0] = 2'd1; sel_r[1] = 2'd2; sel_r[2] = 2'd2;
                sel_c[0] = head.xge2 ? 2'd0 : 2'd1; sel_c[1] = 2'd1; sel_c[2] = 2'd2;
                c_meta.row = head.row;
                c_meta.col = head.col - conv3x3_pkg::COL_OUT_W'(1);
            end
            default: begin
                sel_r[0] = 2'd1; sel_r[1] = 2'd2; sel_r[2] = 2'd2;
                sel_c[0] = head.xge1 ? 2'd1 : 2'd2; sel_c[1] = 2'd2; sel_c[2] = 2'd2;
                c_meta.row = head.row;
                c_meta.col = head.col;
            end
        endcase
        c_meta.done = (kind == conv3x3_pkg::KIND_LAST_EDGE);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                c_pix[i][j] = head.win[sel_r[i]][sel_c[j]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issued <= '0;
        end else if (issue) begin
            r_issued <= issue_last ? '0 : (r_issued | kind_bit);
        end
    end

    // ---------------- filter pipeline: select, multiply, row sums, round
    logic                                  r_c_valid, r_d_valid, r_e_valid;
    conv3x3_pkg::t_win                     r_c_pix;
    conv3x3_pkg::t_meta                    r_c_meta, r_d_meta, r_e_meta, r_out_meta;
    logic signed [conv3x3_pkg::PROD_W-1:0] r_d_prod [3][3];
    logic signed [conv3x3_pkg::ROWSUM_W-1:0] r_e_sum [3];
    logic signed [conv3x3_pkg::SUM_W-1:0]  f_sum;
    conv3x3_pkg::t_pix                     r_out_pix;

    assign f_sum = conv3x3_pkg::SUM_W'(r_e_sum[0]) + conv3x3_pkg::SUM_W'(r_e_sum[1])
                 + conv3x3_pkg::SUM_W'(r_e_sum[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_c_valid   <= issue;
            r_d_valid   <= r_c_valid;
            r_e_valid   <= r_d_valid;
            r_out_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_c_pix  <= c_pix;
            r_c_meta <= c_meta;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_d_prod[i][j] <= $signed(r_coef[i][conv3x3_pkg::COEF_W*j +: conv3x3_pkg::COEF_W])
                                    * $signed({1'b0, r_c_pix[i][j]});
                end
            end
            r_d_meta <= r_c_meta;
            for (int i = 0; i < 3; i++) begin
                r_e_sum[i] <= conv3x3_pkg::ROWSUM_W'(r_d_prod[i][0])
                            + conv3x3_pkg::ROWSUM_W'(r_d_prod[i][1])
                            + conv3x3_pkg::ROWSUM_W'(r_d_prod[i][2]);
            end
            r_e_meta   <= r_d_meta;
            r_out_pix  <= conv3x3_pkg::round_sat(f_sum);
            r_out_meta <= r_e_meta;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_meta.col, r_out_meta.row, r_out_pix};
    assign m_axis_tlast  = r_out_meta.done;

    // ---------------- checks
    `CONV_ASSERT_IMP(a_job_room, job_push, (r_count < conv3x3_pkg::JOB_CNT_W'(conv3x3_pkg::JOB_DEPTH)) || job_pop)
    `CONV_ASSERT_IMP(a_occupancy, r_b_valid, occ <= (conv3x3_pkg::JOB_CNT_W+1)'(conv3x3_pkg::JOB_DEPTH))
    `CONV_ASSERT_NXT(a_issued_in_mask, issue && !issue_last, (r_issued & ~head.mask) == '0)

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the 3x3 replicate-border convolution block.
// Needs conv3x3_pkg and conv2d_3x3_replicate_border; streams frames of varied
// geometry and kernel and checks every result against an in-bench raster model.

module tb_top;

    localparam int LINE_MAX        = 1024;
    localparam int ROWS_MAX        = 4096;
    localparam int SETTLE_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MISMATCH_SHOWN  = 10;
    localparam int PHASE_PIXELS    = 56;
    localparam int SAT_RUN_PIXELS  = 6;

    // result fields in master tdata, lowest first
    localparam int PIX_LSB = 0;
    localparam int ROW_LSB = conv3x3_pkg::PIX_W;
    localparam int COL_LSB = ROW_LSB + conv3x3_pkg::ROW_W;
    localparam int PAD_LSB = COL_LSB + conv3x3_pkg::COL_OUT_W;
    localparam int PAD_W   = conv3x3_pkg::TDATA_W - PAD_LSB;

    localparam logic [conv3x3_pkg::COEF_W-1:0] COEF_MAX  = 16'h7FFF;
    localparam logic [conv3x3_pkg::COEF_W-1:0] COEF_MIN  = 16'h8000;
    localparam logic [conv3x3_pkg::COEF_W-1:0] COEF_HALF = 16'h0800;
    localparam logic [conv3x3_pkg::COEF_W-1:0] COEF_BOX  = 16'h01C7;

    typedef enum int {
        KERN_FULL_RANGE,
        KERN_UNIT_RANGE,
        KERN_HALF_STEPS,
        KERN_BOX_BLUR
    } t_kern_style;

    typedef struct {
        conv3x3_pkg::t_pix                pix;
        logic [conv3x3_pkg::ROW_W-1:0]     row;
        logic [conv3x3_pkg::COL_OUT_W-1:0] col;
        logic                              frame_end;
    } t_filtered_px;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [conv3x3_pkg::PIX_W-1:0]       s_axis_tdata;   // pixel_in [7:0]
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    // pixel_out [7:0], out_row [19:8], out_col [29:20], zero [31:30]
    logic [conv3x3_pkg::TDATA_W-1:0]     m_axis_tdata;
    logic                                m_axis_tlast;
    logic                                i_cfg_we;
    conv3x3_pkg::t_cfg_addr              i_cfg_addr;
    logic [conv3x3_pkg::COEF_REG_W-1:0]  i_cfg_wdata;

    // predictor state
    logic [conv3x3_pkg::FW_W-1:0]        geo_width;
    logic [conv3x3_pkg::FH_W-1:0]        geo_height;
    logic [conv3x3_pkg::COEF_REG_W-1:0]  kern_rows [3];
    conv3x3_pkg::t_pix                   older_ln [LINE_MAX];
    conv3x3_pkg::t_pix                   newer_ln [LINE_MAX];
    conv3x3_pkg::t_pix                   win_px [3][3];
    int unsigned                         cur_col;
    int unsigned                         cur_row;

    t_filtered_px           pending_px [$];
    t_filtered_px           want_px;
    int                     error_count = 0;
    int                     quiet_cycles = 0;
    int                     src_idle_pct = 0;
    int                     snk_stall_pct = 0;

    conv2d_3x3_replicate_border #(
        .MAX_WIDTH(LINE_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // -------------------------------------------------------------- predictor

    function automatic int unsigned eff_width();
        int unsigned w;
        w = int'(geo_width);
        if (w == 0) w = 1;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = int'(geo_height);
        if (h == 0) h = 1;
        if (h > ROWS_MAX) h = ROWS_MAX;
        return h;
    endfunction

    function automatic conv3x3_pkg::t_pix convolve_window(input int rt, rm, rb, cl, cm, cr);
        int                                    rsel [3];
        int                                    csel [3];
        longint                                acc;
        longint                                quo;
        logic [conv3x3_pkg::FRAC_W-1:0]        frac;
        logic signed [conv3x3_pkg::COEF_W-1:0] coef;
        rsel = '{rt, rm, rb};
        csel = '{cl, cm, cr};
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                coef = kern_rows[i][conv3x3_pkg::COEF_W*j +: conv3x3_pkg::COEF_W];
                acc += longint'(coef) * longint'(win_px[rsel[i]][csel[j]]);
            end
        end
        // floor to whole pixels, then round half to even
        quo  = acc >>> conv3x3_pkg::FRAC_W;
        frac = acc[conv3x3_pkg::FRAC_W-1:0];
        if (frac > conv3x3_pkg::FRAC_HALF || (frac == conv3x3_pkg::FRAC_HALF && quo[0])) quo++;
        if (quo < 0) return '0;
        if (quo > 255) return '1;
        return quo[conv3x3_pkg::PIX_W-1:0];
    endfunction

    function automatic void expect_result(input int rt, rm, rb, cl, cm, cr,
                                          input int unsigned row, col,
                                          input logic last_px);
        t_filtered_px res_px;
        res_px.pix       = convolve_window(rt, rm, rb, cl, cm, cr);
        res_px.row       = row[conv3x3_pkg::ROW_W-1:0];
        res_px.col       = col[conv3x3_pkg::COL_OUT_W-1:0];
        res_px.frame_end = last_px;
        pending_px.push_back(res_px);
    endfunction

    function automatic void predict_pixel(input conv3x3_pkg::t_pix p);
        int unsigned       w, h, x, y;
        conv3x3_pkg::t_pix top_px, mid_px;
        logic              row_end, last_row;
        w = eff_width();
        h = eff_height();
        // a geometry shrunk mid-frame ends the row or the frame right here
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= h) cur_row = 0;
        x = cur_col;
        y = cur_row;

        mid_px = (y >= 1) ? newer_ln[x] : p;
        top_px = (y >= 2) ? older_ln[x] : mid_px;
        older_ln[x] = newer_ln[x];
        newer_ln[x] = p;
        for (int r = 0; r < 3; r++) begin
            win_px[r][0] = win_px[r][1];
            win_px[r][1] = win_px[r][2];
        end
        win_px[0][2] = top_px;
        win_px[1][2] = mid_px;
        win_px[2][2] = p;

        row_end  = (x == w - 1);
        last_row = (y == h - 1);
        if (y >= 1) begin
            if (x >= 1) expect_result(0, 1, 2, (x >= 2) ? 0 : 1, 1, 2, y - 1, x - 1, 1'b0);
            if (row_end) expect_result(0, 1, 2, (x >= 1) ? 1 : 2, 2, 2, y - 1, x, 1'b0);
        end
        // the last row is filtered again with its bottom neighbor replicated
        if (last_row) begin
            if (x >= 1) expect_result(1, 2, 2, (x >= 2) ? 0 : 1, 1, 2, y, x - 1, 1'b0);
            if (row_end) expect_result(1, 2, 2, (x >= 1) ? 1 : 2, 2, 2, y, x, 1'b1);
        end

        if (row_end) begin
            cur_col = 0;
            cur_row = last_row ? 0 : y + 1;
        end else begin
            cur_col = x + 1;
        end
    endfunction

    function automatic int frame_pixels();
        return eff_width() * eff_height();
    endfunction

    function automatic conv3x3_pkg::t_pix next_pixel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return conv3x3_pkg::t_pix'($urandom);
        endcase
    endfunction

    function automatic logic [conv3x3_pkg::COEF_REG_W-1:0] random_coef_row(
        input t_kern_style style
    );
        logic [conv3x3_pkg::COEF_REG_W-1:0] row_val;
        int                                 tap;
        for (int k = 0; k < 3; k++) begin
            case (style)
                KERN_FULL_RANGE: tap = $urandom;
                KERN_UNIT_RANGE: tap = int'($urandom_range(8192)) - 4096;
                KERN_HALF_STEPS: tap = (int'($urandom_range(8)) - 4) * 2048;
                default:         tap = int'(COEF_BOX);
            endcase
            row_val[conv3x3_pkg::COEF_W*k +: conv3x3_pkg::COEF_W] =
                tap[conv3x3_pkg::COEF_W-1:0];
        end
        return row_val;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_pixel(input conv3x3_pkg::t_pix p);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_pixel(p);
    endtask

    task automatic send_frame();
        int n;
        n = frame_pixels();
        repeat (n) send_pixel(next_pixel());
    endtask

    // drain all results, then give the pipeline time to empty
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after its last write
    task automatic reg_write(input conv3x3_pkg::t_cfg_addr addr,
                             input logic [conv3x3_pkg::COEF_REG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            conv3x3_pkg::REG_FRAME_WIDTH:  geo_width    = data[conv3x3_pkg::FW_W-1:0];
            conv3x3_pkg::REG_FRAME_HEIGHT: geo_height   = data[conv3x3_pkg::FH_W-1:0];
            conv3x3_pkg::REG_COEF_TOP:     kern_rows[0] = data;
            conv3x3_pkg::REG_COEF_MID:     kern_rows[1] = data;
            conv3x3_pkg::REG_COEF_BOT:     kern_rows[2] = data;
            default: ;
        endcase
    endtask

    task automatic write_geometry(input int w, input int h);
        logic [conv3x3_pkg::COEF_REG_W-1:0] junk;
        settle_block();
        // random upper bits must be ignored
        junk = conv3x3_pkg::COEF_REG_W'({$urandom, $urandom});
        reg_write(conv3x3_pkg::REG_FRAME_WIDTH,
                  {junk[conv3x3_pkg::COEF_REG_W-1:conv3x3_pkg::FW_W],
                   w[conv3x3_pkg::FW_W-1:0]});
        junk = conv3x3_pkg::COEF_REG_W'({$urandom, $urandom});
        reg_write(conv3x3_pkg::REG_FRAME_HEIGHT,
                  {junk[conv3x3_pkg::COEF_REG_W-1:conv3x3_pkg::FH_W],
                   h[conv3x3_pkg::FH_W-1:0]});
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_kernel(input logic [conv3x3_pkg::COEF_REG_W-1:0] top, mid, bot);
        settle_block();
        reg_write(conv3x3_pkg::REG_COEF_TOP, top);
        reg_write(conv3x3_pkg::REG_COEF_MID, mid);
        reg_write(conv3x3_pkg::REG_COEF_BOT, bot);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_random_kernel();
        t_kern_style style;
        style = t_kern_style'($urandom_range(KERN_BOX_BLUR));
        write_kernel(random_coef_row(style), random_coef_row(style), random_coef_row(style));
    endtask

    task automatic poke_unused_regs();
        settle_block();
        for (int a = int'(conv3x3_pkg::REG_COEF_BOT) + 1;
             a < (1 << conv3x3_pkg::CFG_ADDR_W); a++) begin
            reg_write(conv3x3_pkg::t_cfg_addr'(a),
                      conv3x3_pkg::COEF_REG_W'({$urandom, $urandom}));
        end
        i_cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------- checker

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_px.size() == 0) begin
                if (error_count < MISMATCH_SHOWN) begin
                    $display("%0t: unexpected result tdata=%h tlast=%b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                error_count++;
            end else begin
                want_px = pending_px.pop_front();
                if (m_axis_tdata[PIX_LSB +: conv3x3_pkg::PIX_W] !== want_px.pix ||
                    m_axis_tdata[ROW_LSB +: conv3x3_pkg::ROW_W] !== want_px.row ||
                    m_axis_tdata[COL_LSB +: conv3x3_pkg::COL_OUT_W] !== want_px.col ||
                    m_axis_tdata[PAD_LSB +: PAD_W] !== '0 ||
                    m_axis_tlast !== want_px.frame_end) begin
                    if (error_count < MISMATCH_SHOWN) begin
                        $display("%0t: mismatch expected pix=%0d row=%0d col=%0d last=%b",
                                 $time, want_px.pix, want_px.row, want_px.col,
                                 want_px.frame_end);
                        $display("%0t:          got pix=%0d row=%0d col=%0d last=%b pad=%0d",
                                 $time, m_axis_tdata[PIX_LSB +: conv3x3_pkg::PIX_W],
                                 m_axis_tdata[ROW_LSB +: conv3x3_pkg::ROW_W],
                                 m_axis_tdata[COL_LSB +: conv3x3_pkg::COL_OUT_W],
                                 m_axis_tlast, m_axis_tdata[PAD_LSB +: PAD_W]);
                    end
                    error_count++;
                end
            end
        end
    end

    // the longest legal quiet stretch is a receiver stall run plus a settle pause
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------ tests

    // run under the reset geometry and identity kernel, then cut the row short
    task automatic test_reset_defaults();
        repeat (3) send_pixel(next_pixel());
        write_geometry(2, 2);
        repeat (2) send_pixel(next_pixel());
    endtask

    task automatic test_degenerate_geometry();
        write_geometry(0, 0);
        send_pixel('0);
        send_pixel('1);
        write_geometry(3, 1);
        send_frame();
        write_geometry(1, 3);
        send_frame();
        poke_unused_regs();
        send_frame();
    endtask

    task automatic test_rounding_and_clamp();
        write_geometry(2, 2);
        // half-weight center tap: 0.5, 1.5, 127.0, 127.5
        write_kernel('0, {16'h0, COEF_HALF, 16'h0}, '0);
        send_pixel(8'd1);
        send_pixel(8'd3);
        send_pixel(8'd254);
        send_pixel(8'd255);
        write_kernel({3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}});
        send_frame();
        write_kernel({3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}});
        send_frame();
    endtask

    task automatic test_midframe_height_cut();
        write_kernel(random_coef_row(KERN_UNIT_RANGE), random_coef_row(KERN_UNIT_RANGE),
                     random_coef_row(KERN_UNIT_RANGE));
        write_geometry(2, 4);
        repeat (4) send_pixel(next_pixel());
        write_geometry(2, 2);
        send_frame();
    endtask

    // start a frame of oversize geometry, then cut it with a one-pixel frame
    task automatic test_geometry_saturation();
        write_random_kernel();
        write_geometry((1 << conv3x3_pkg::FW_W) - 1, 1);
        repeat (SAT_RUN_PIXELS) send_pixel(next_pixel());
        write_geometry(1, 1);
        send_pixel(next_pixel());
        write_geometry(1, (1 << conv3x3_pkg::FH_W) - 1);
        repeat (SAT_RUN_PIXELS) send_pixel(next_pixel());
        write_geometry(1, 1);
        send_pixel(next_pixel());
    endtask

    task automatic run_random_phase(input int src_pct, input int snk_pct);
        int sent;
        int w;
        int h;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        sent = 0;
        while (sent < PHASE_PIXELS) begin
            if ($urandom_range(2) == 0) write_random_kernel();
            if ($urandom_range(7) == 0) begin
                w = $urandom_range(64, 13);
                h = $urandom_range(2, 1);
            end else begin
                w = $urandom_range(12);
                h = $urandom_range(6);
            end
            write_geometry(w, h);
            if ($urandom_range(15) == 0) poke_unused_regs();
            sent += frame_pixels();
            send_frame();
        end
    endtask

    task automatic test_random_streams();
        run_random_phase(0, 0);
        run_random_phase(87, 0);
        run_random_phase(0, 87);
        run_random_phase(20, 20);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= conv3x3_pkg::REG_FRAME_WIDTH;
        i_cfg_wdata   <= '0;
        geo_width     = conv3x3_pkg::FW_RESET;
        geo_height    = conv3x3_pkg::FH_RESET;
        kern_rows[0]  = '0;
        kern_rows[1]  = conv3x3_pkg::COEF_MID_RESET;
        kern_rows[2]  = '0;
        foreach (win_px[r, c]) win_px[r][c] = '0;
        cur_col = 0;
        cur_row = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_degenerate_geometry();
        test_rounding_and_clamp();
        test_midframe_height_cut();
        test_geometry_saturation();
        test_random_streams();

        settle_block();
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
